// File: src/s2i_pkg.sv
// ----------------------------------------------------------------------------
// s2i_pkg
// Shared types, character codes and helpers for the string to int32 parser.
// ----------------------------------------------------------------------------
package s2i_pkg;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned BASE_W     = 6;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned MAX_CHARS_DEF = 4096;
  localparam int unsigned OFFSET_LIMIT  = 4095;

  localparam logic [BASE_W-1:0]  BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_HEX   = 6'd16;
  localparam logic [VALUE_W-1:0] POS_LIMIT  = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] NEG_LIMIT  = 32'h8000_0000;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
  localparam logic [DIGIT_W-1:0] LETTER_BIAS = 6'd10;

  typedef enum logic [2:0] {
    PH_BLANKS = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              first_char;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] parsed_value;
    logic                      range_error;
    logic [OFFSET_W-1:0]       end_offset;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] value;
  } digit_t;

  function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
    digit_t d;
    d.valid = 1'b1;
    d.value = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.value = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      d.value = DIGIT_W'(c - CH_LC_A) + LETTER_BIAS;
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      d.value = DIGIT_W'(c - CH_UC_A) + LETTER_BIAS;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

// File: src/s2i_in_stage.sv
// ----------------------------------------------------------------------------
// s2i_in_stage
// Input register: holds one character request until the parse step takes it.
// ----------------------------------------------------------------------------
module s2i_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  s2i_pkg::req_t  req_i,
  input  logic           advance_i,
  output logic           valid_o,
  output s2i_pkg::req_t  req_o
);
  import s2i_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;
  logic load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// File: src/s2i_parse_core.sv
// ----------------------------------------------------------------------------
// s2i_parse_core
// Parse state, radix register and the per-character step with clamped result.
// ----------------------------------------------------------------------------
module s2i_parse_core #(
  parameter int unsigned MaxChars = s2i_pkg::MAX_CHARS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [s2i_pkg::BASE_W-1:0]      cfg_wdata_i,
  input  logic                            step_i,
  input  s2i_pkg::req_t                   req_i,
  output logic                            emit_o,
  output s2i_pkg::result_t                result_o
);
  import s2i_pkg::*;

  localparam int unsigned CapInt =
    ((MaxChars - 1) < OFFSET_LIMIT) ? (MaxChars - 1) : OFFSET_LIMIT;
  localparam logic [OFFSET_W-1:0] PosCap = OFFSET_W'(CapInt);

  logic [BASE_W-1:0]   base_q;
  phase_e              phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [VALUE_W-1:0]  mag_q, mag_d;
  logic                ovf_q, ovf_d;
  logic                seen_q, seen_d;
  logic [OFFSET_W-1:0] pos_q, pos_d;

  phase_e              ph_cur;
  logic                neg_cur, ovf_cur, seen_cur;
  logic [VALUE_W-1:0]  mag_cur;
  logic [OFFSET_W-1:0] pos_cur;
  digit_t              dig;
  logic [VALUE_W+BASE_W-1:0] prod;
  logic [VALUE_W+BASE_W:0]   acc;
  logic                stop_c;

  assign ph_cur   = req_i.first_char ? PH_BLANKS : phase_q;
  assign neg_cur  = req_i.first_char ? 1'b0 : neg_q;
  assign mag_cur  = req_i.first_char ? '0 : mag_q;
  assign ovf_cur  = req_i.first_char ? 1'b0 : ovf_q;
  assign seen_cur = req_i.first_char ? 1'b0 : seen_q;
  assign pos_cur  = req_i.first_char ? '0 : pos_q;

  assign dig  = digit_of(req_i.char_code);
  assign prod = mag_cur * base_q;
  assign acc  = {1'b0, prod} + (VALUE_W + BASE_W + 1)'(dig.value);

  // next state
  always_comb begin
    logic c_taken;
    c_taken = 1'b0;
    phase_d = ph_cur;
    neg_d   = neg_cur;
    mag_d   = mag_cur;
    ovf_d   = ovf_cur;
    seen_d  = seen_cur;
    stop_c  = 1'b0;
    pos_d   = (pos_cur < PosCap) ? pos_cur + 1'b1 : pos_cur;

    if (phase_d == PH_BLANKS) begin
      if (req_i.char_code == CH_SPACE || req_i.char_code == CH_TAB) begin
        c_taken = 1'b1;
      end else if (req_i.char_code == CH_PLUS) begin
        phase_d = PH_SIGNED;
        c_taken = 1'b1;
      end else if (req_i.char_code == CH_MINUS) begin
        neg_d   = 1'b1;
        phase_d = PH_SIGNED;
        c_taken = 1'b1;
      end else begin
        phase_d = PH_SIGNED;
      end
    end
    if (!c_taken && phase_d == PH_SIGNED) begin
      if (base_q == BASE_HEX && req_i.char_code == CH_ZERO) begin
        phase_d = PH_ZERO;
        c_taken = 1'b1;
      end else begin
        phase_d = PH_DIGITS;
      end
    end
    if (!c_taken && phase_d == PH_ZERO) begin
      phase_d = PH_DIGITS;
      if (req_i.char_code == CH_LC_X || req_i.char_code == CH_UC_X) begin
        c_taken = 1'b1;
      end else begin
        // the held zero counts as a digit; magnitude stays zero
        seen_d = 1'b1;
      end
    end
    if (!c_taken && phase_d == PH_DIGITS) begin
      if (req_i.char_code == CH_NUL || !dig.valid || dig.value >= base_q) begin
        stop_c  = 1'b1;
        phase_d = PH_DONE;
      end else begin
        seen_d = 1'b1;
        if (acc[VALUE_W+BASE_W:VALUE_W] != '0) begin
          ovf_d = 1'b1;
          mag_d = '1;
        end else begin
          mag_d = acc[VALUE_W-1:0];
        end
      end
    end
  end

  // result
  always_comb begin
    result_o.range_error  = 1'b0;
    result_o.parsed_value = signed'(mag_d);
    if (neg_d) begin
      if (ovf_d || mag_d > NEG_LIMIT) begin
        result_o.parsed_value = signed'(NEG_LIMIT);
        result_o.range_error  = 1'b1;
      end else begin
        result_o.parsed_value = signed'(VALUE_W'(0) - mag_d);
      end
    end else if (ovf_d || mag_d > POS_LIMIT) begin
      result_o.parsed_value = signed'(POS_LIMIT);
      result_o.range_error  = 1'b1;
    end
    result_o.end_offset = seen_d ? pos_cur : '0;
    emit_o              = step_i && stop_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RESET;
      phase_q <= PH_BLANKS;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
      seen_q  <= 1'b0;
      pos_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (step_i) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        mag_q   <= mag_d;
        ovf_q   <= ovf_d;
        seen_q  <= seen_d;
        pos_q   <= pos_d;
      end
    end
  end

endmodule

// File: src/s2i_out_stage.sv
// ----------------------------------------------------------------------------
// s2i_out_stage
// Result register: holds a parsed result until the receiver takes it.
// ----------------------------------------------------------------------------
module s2i_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              emit_i,
  input  s2i_pkg::result_t  result_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output s2i_pkg::result_t  result_o
);
  import s2i_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign advance_o = !valid_q || !out_stall_i;
  assign valid_d   = advance_o ? emit_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && emit_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// File: src/string_to_int32_parser_core.sv
// ----------------------------------------------------------------------------
// string_to_int32_parser_core
// Streaming strtol-style parser: one character a request, saturating int32.
//
// Input channel: char_code_i with first_char_i, taken when in_valid_i is high
// and in_stall_o is low. Set first_char_i on a string's first character.
// Output channel: parsed_value_o, range_error_o, end_offset_o, taken when
// out_valid_o is high and out_stall_i is low. One result per string, on
// the character that ends the parse; later characters give none.
// Radix: cfg_we_i writes cfg_wdata_i into the base register (reset 10);
// write only while no string is in flight.
// Each character is parsed from the input register; its result is registered
// in the result register. Throughput: one character per cycle while no
// result stalls, set by the single multiply-add of the accumulator, which
// sits between the input and result registers.
// Reset clears the parse state and both registers' valid bits; base is 10.
// A stalled result holds; the input register then fills and in_stall_o
// rises until the result is taken.
// ----------------------------------------------------------------------------
module string_to_int32_parser_core #(
  parameter int unsigned MaxChars = s2i_pkg::MAX_CHARS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [s2i_pkg::BASE_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [s2i_pkg::CHAR_W-1:0]          char_code_i,
  input  logic                                first_char_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [s2i_pkg::VALUE_W-1:0]  parsed_value_o,
  output logic                                range_error_o,
  output logic [s2i_pkg::OFFSET_W-1:0]        end_offset_o
);
  import s2i_pkg::*;

  req_t    req_in, req_s1;
  logic    s1_valid;
  logic    advance;
  logic    emit;
  result_t result_c, result_q;

  assign req_in.char_code  = char_code_i;
  assign req_in.first_char = first_char_i;

  s2i_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (req_in),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .req_o      (req_s1)
  );

  s2i_parse_core #(
    .MaxChars (MaxChars)
  ) u_parse_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (s1_valid && advance),
    .req_i       (req_s1),
    .emit_o      (emit),
    .result_o    (result_c)
  );

  s2i_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .result_i    (result_c),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_q)
  );

  assign parsed_value_o = result_q.parsed_value;
  assign range_error_o  = result_q.range_error;
  assign end_offset_o   = result_q.end_offset;

  a_clamp_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |->
      (parsed_value_o == signed'(POS_LIMIT) || parsed_value_o == signed'(NEG_LIMIT)))
    else $error("clamped result not at an int32 limit");

  a_clamp_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (end_offset_o != '0))
    else $error("clamped result without a digit offset");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("request taken while result stalled and input register full");

  a_emit_needs_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (s1_valid && advance))
    else $error("result produced without a request in the input register");

endmodule

// File: dv/string_to_int32_parser_core_test.sv
// ----------------------------------------------------------------------------
// string_to_int32_parser_core_test
// Self-checking bench for the streaming string to int32 parser. Strings are
// fed one character per request; a tracker class mirrors the parse state
// and the radix register, queues the value each stopping character should
// give and checks every taken result against it. A directed opening covers
// empty and blank strings, a bare sign and prefix, a saturating overflow and
// blanks cut off by a new string. Random strings then run under several
// radix settings and idle/stall mixes, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module string_to_int32_parser_core_test;
  import s2i_pkg::*;

  localparam int unsigned POS_CAP =
    (MAX_CHARS_DEF - 1 < OFFSET_LIMIT) ? MAX_CHARS_DEF - 1 : OFFSET_LIMIT;

  class int_parse_tracker;
    logic [BASE_W-1:0]  base;
    phase_e             phase;
    bit                 negative;
    logic [VALUE_W-1:0] magnitude;
    bit                 overflow;
    bit                 digit_seen;
    int unsigned        position;
    result_t            expected_q[$];
    int unsigned        fails;

    function new();
      base  = BASE_RESET;
      fails = 0;
      clear();
    endfunction

    function void clear();
      phase      = PH_BLANKS;
      negative   = 1'b0;
      magnitude  = '0;
      overflow   = 1'b0;
      digit_seen = 1'b0;
      position   = 0;
    endfunction

    function void add_digit(int unsigned d);
      logic [63:0] acc;
      acc = 64'(magnitude) * 64'(base) + 64'(d);
      if (acc > 64'h0000_0000_FFFF_FFFF) begin
        overflow  = 1'b1;
        magnitude = '1;
      end else begin
        magnitude = acc[VALUE_W-1:0];
      end
      digit_seen = 1'b1;
    endfunction

    function void note_char(logic [CHAR_W-1:0] c, logic first);
      bit      taken;
      int      weight;
      result_t res;
      if (first) clear();
      taken = 1'b0;
      if (phase == PH_BLANKS) begin
        if (c == CH_SPACE || c == CH_TAB) begin
          taken = 1'b1;
        end else if (c == CH_PLUS) begin
          phase = PH_SIGNED;
          taken = 1'b1;
        end else if (c == CH_MINUS) begin
          negative = 1'b1;
          phase    = PH_SIGNED;
          taken    = 1'b1;
        end else begin
          phase = PH_SIGNED;
        end
      end
      if (!taken && phase == PH_SIGNED) begin
        if (base == BASE_HEX && c == CH_ZERO) begin
          phase = PH_ZERO;
          taken = 1'b1;
        end else begin
          phase = PH_DIGITS;
        end
      end
      if (!taken && phase == PH_ZERO) begin
        phase = PH_DIGITS;
        if (c == CH_LC_X || c == CH_UC_X) taken = 1'b1;
        else add_digit(0);
      end
      if (!taken && phase == PH_DIGITS) begin
        if (c >= CH_ZERO && c <= CH_NINE) weight = int'(c - CH_ZERO);
        else if (c >= CH_LC_A && c <= CH_LC_Z) weight = int'(c - CH_LC_A) + int'(LETTER_BIAS);
        else if (c >= CH_UC_A && c <= CH_UC_Z) weight = int'(c - CH_UC_A) + int'(LETTER_BIAS);
        else weight = -1;
        if (c == CH_NUL || weight < 0 || weight >= int'(base)) begin
          res.range_error = 1'b0;
          if (negative) begin
            if (overflow || magnitude > NEG_LIMIT) begin
              res.parsed_value = NEG_LIMIT;
              res.range_error  = 1'b1;
            end else begin
              res.parsed_value = 0 - magnitude;
            end
          end else begin
            if (overflow || magnitude > POS_LIMIT) begin
              res.parsed_value = POS_LIMIT;
              res.range_error  = 1'b1;
            end else begin
              res.parsed_value = magnitude;
            end
          end
          res.end_offset = digit_seen ? OFFSET_W'(position) : '0;
          expected_q.push_back(res);
          phase = PH_DONE;
        end else begin
          add_digit(weight);
        end
      end
      if (position < POS_CAP) position++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: parsed_value %0d range_error %0d end_offset %0d",
               got.parsed_value, got.range_error, got.end_offset);
        fails++;
      end else begin
        want = expected_q.pop_front();
        if (got.parsed_value !== want.parsed_value) begin
          $error("parsed_value: expected %0d, got %0d", want.parsed_value, got.parsed_value);
          fails++;
        end
        if (got.range_error !== want.range_error) begin
          $error("range_error: expected %0d, got %0d", want.range_error, got.range_error);
          fails++;
        end
        if (got.end_offset !== want.end_offset) begin
          $error("end_offset: expected %0d, got %0d", want.end_offset, got.end_offset);
          fails++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       cfg_we_i     = 1'b0;
  logic [BASE_W-1:0]          cfg_wdata_i  = '0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic [CHAR_W-1:0]          char_code_i  = '0;
  logic                       first_char_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic signed [VALUE_W-1:0]  parsed_value_o;
  logic                       range_error_o;
  logic [OFFSET_W-1:0]        end_offset_o;

  int_parse_tracker tracker;
  result_t          seen_result;
  int unsigned      send_idle_pct  = 0;
  int unsigned      recv_stall_pct = 0;
  logic             hold_off       = 1'b0;
  int unsigned      sent_items     = 0;

  string       limit_text[6] = '{"2147483647", "2147483648", "2147483649",
                                 "4294967295", "4294967296", "99999999999"};
  int unsigned base_plan[10] = '{10, 16, 2, 36, 0, 1, 63, 37, 8, 16};
  int unsigned send_plan[4]  = '{0, 85, 0, 6};
  int unsigned recv_plan[4]  = '{0, 0, 85, 6};

  string_to_int32_parser_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .first_char_i   (first_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .parsed_value_o (parsed_value_o),
    .range_error_o  (range_error_o),
    .end_offset_o   (end_offset_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_result.parsed_value = parsed_value_o;
      seen_result.range_error  = range_error_o;
      seen_result.end_offset   = end_offset_o;
      tracker.check_result(seen_result);
    end
  end

  function automatic logic [CHAR_W-1:0] glyph(int unsigned v);
    if (v < 10) return CH_ZERO + CHAR_W'(v);
    return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + CHAR_W'(v - 10);
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    char_code_i  <= c;
    first_char_i <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_char(c, first);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic [CHAR_W-1:0] term);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
    send_char(term, s.len() == 0);
  endtask

  task automatic set_base(input logic [BASE_W-1:0] b);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    tracker.base = b;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_string();
    logic [CHAR_W-1:0] text[$];
    int unsigned       radix;
    int unsigned       n;
    string             lit;
    radix = (tracker.base > 36) ? 36 : tracker.base;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(4, 1);
      repeat (n) send_char(CHAR_W'($urandom_range(255)), $urandom_range(3) == 0);
    end else begin
      repeat ($urandom_range(3)) text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
      case ($urandom_range(2))
        1: text.push_back(CH_PLUS);
        2: text.push_back(CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(9) == 0) begin
        lit = limit_text[$urandom_range(5)];
        for (int i = 0; i < lit.len(); i++) text.push_back(lit[i]);
      end else begin
        if ($urandom_range(99) < ((tracker.base == BASE_HEX) ? 50 : 5)) begin
          text.push_back(CH_ZERO);
          text.push_back($urandom_range(1) ? CH_LC_X : CH_UC_X);
        end
        n = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(10);
        repeat (n) begin
          text.push_back(glyph((radix >= 2) ? $urandom_range(radix - 1) : $urandom_range(35)));
        end
        if (radix < 36 && $urandom_range(19) == 0) text.push_back(glyph($urandom_range(35, radix)));
      end
      text.push_back($urandom_range(1) ? CH_NUL : CHAR_W'($urandom_range(255)));
      repeat ($urandom_range(2)) text.push_back(CHAR_W'($urandom_range(255)));
      foreach (text[i]) send_char(text[i], i == 0);
    end
  endtask

  initial begin
    int unsigned goal;
    tracker = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_text("", CH_NUL);
    send_text(" \t", CH_NUL);
    send_text("-", CH_NUL);
    send_text("+9", 8'hFF);
    send_char(8'h80, 1'b0);
    set_base(BASE_HEX);
    send_text("0x", "g");
    send_text("-0F", CH_NUL);
    set_base(6'd36);
    send_text("zzzzzzz", CH_NUL);
    set_base(BASE_RESET);
    for (int i = 0; i < 20; i++) send_char(CH_SPACE, i == 0);
    send_text("7", CH_NUL);

    for (int p = 0; p < 10; p++) begin
      set_base(BASE_W'(base_plan[p]));
      send_idle_pct  = send_plan[p % 4];
      recv_stall_pct = recv_plan[p % 4];
      if (p == 0) begin
        fork
          begin
            @(posedge clk_i);
            hold_off <= 1'b1;
            repeat (60) @(posedge clk_i);
            hold_off <= 1'b0;
          end
        join_none
      end
      goal = sent_items + 45;
      while (sent_items < goal) send_random_string();
    end

    in_valid_i     <= 1'b0;
    recv_stall_pct  = 0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (tracker.fails == 0) begin
      $display("string_to_int32_parser_core_test: clean");
    end else begin
      $display("string_to_int32_parser_core_test: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("string_to_int32_parser_core_test: errors");
    $finish;
  end

endmodule
